/* rtl/dtof_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtof_pkg
// shared constants for the double-sided two-way ranging time of flight block
// ----------------------------------------------------------------------------
package dtof_pkg;

	localparam int unsigned STAMP_BITS_DEF = 32;
	localparam int unsigned TICK_BITS      = 34;
	localparam int unsigned WHOLE_BITS     = 16;
	localparam int unsigned HUND_BITS      = 7;
	localparam int unsigned SCALE_BITS     = 32;
	localparam int unsigned ADDR_BITS      = 3;

	localparam logic [31:0] SCALE_RESET    = 32'd3073870;
	localparam logic [6:0]  CM_DIV         = 7'd100;
	localparam logic [6:0]  HUND_MAX       = 7'd99;
	localparam logic [15:0] WHOLE_MAX      = 16'hFFFF;

	// whole_cm overflows once hundredths reach 65536 * 100
	localparam int unsigned HLOW_BITS      = 23;
	localparam logic [22:0] SAT_LIMIT      = 23'd6553600;

	// reciprocal of 100: ceil(2^32 / 100), exact for values below 2^30
	localparam int unsigned RECIP_BITS     = 26;
	localparam int unsigned RECIP_SHIFT    = 32;
	localparam logic [25:0] RECIP_K        = 26'd42949673;

	// register index of the scale
	localparam logic REG_SCALE = 1'b0;

endpackage

/* rtl/ds_twr_time_of_flight_top.sv */
`timescale 1ns / 1ps
// throughput: one word per cycle while the output is not stalled; the whole pipeline advances together
// the divider is one restoring stage per quotient bit, STAMP_BITS stages
// reset: arst_n clears all valid bits and loads the scale register with its default
// ----------------------------------------------------------------------------
// ds_twr_time_of_flight_top
// asymmetric double-sided two-way ranging: time of flight and distance in cm
// ----------------------------------------------------------------------------
module ds_twr_time_of_flight_top #(
	parameter int unsigned STAMP_BITS = dtof_pkg::STAMP_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// apb configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dtof_pkg::ADDR_BITS-1:0]    paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	// input word
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [31:0]                       peer_poll_sent,
	input  logic [31:0]                       peer_reply_seen,
	input  logic [31:0]                       peer_final_sent,
	input  logic [39:0]                       local_poll_seen,
	input  logic [39:0]                       local_reply_sent,
	input  logic [39:0]                       local_final_seen,
	// output word
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [dtof_pkg::TICK_BITS-1:0] flight_ticks,
	output logic [dtof_pkg::WHOLE_BITS-1:0]   whole_cm,
	output logic [dtof_pkg::HUND_BITS-1:0]    hundredths_cm,
	output logic                              was_negative,
	output logic                              zero_divisor,
	output logic                              saturated
);
	import dtof_pkg::*;

	localparam int unsigned W  = STAMP_BITS;
	localparam int unsigned DW = STAMP_BITS + 2;   // interval sum width
	localparam int unsigned PW = STAMP_BITS + SCALE_BITS;

	// ---------------------------------------------------------------- config
	logic [SCALE_BITS-1:0] scale_q;

	assign pready = 1'b1;
	// register index is the address bit above the byte offset
	assign prdata = (paddr[2] == REG_SCALE) ? scale_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_SCALE) begin
			scale_q <= pwdata;
		end
	end

	// -------------------------------------------------------------- handshake
	// every stage moves when the output register is free or being emptied,
	// so a held output freezes the whole line without loss
	logic adv;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// ---------------------------------------------------- stage 1: intervals
	// wrapping differences of the low STAMP_BITS of each stamp
	logic [W-1:0]  ra_s1, rb_s1, da_s1, db_s1;
	logic [DW-1:0] den_s1;
	logic          v_s1;
	logic [W-1:0]  ra_c, rb_c, da_c, db_c;

	always_comb begin
		ra_c = W'(peer_reply_seen)  - W'(peer_poll_sent);
		rb_c = W'(local_final_seen) - W'(local_reply_sent);
		da_c = W'(peer_final_sent)  - W'(peer_reply_seen);
		db_c = W'(local_reply_sent) - W'(local_poll_seen);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ra_s1  <= ra_c;
			rb_s1  <= rb_c;
			da_s1  <= da_c;
			db_s1  <= db_c;
			den_s1 <= DW'(ra_c) + DW'(rb_c) + DW'(da_c) + DW'(db_c);
		end
	end

	// ---------------------------------------------------- stage 2: products
	logic [2*W-1:0] pos_s2, sub_s2;
	logic [DW-1:0]  den_s2;
	logic           v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s2 <= (2*W)'(ra_s1) * (2*W)'(rb_s1);
			sub_s2 <= (2*W)'(da_s1) * (2*W)'(db_s1);
			den_s2 <= den_s1;
		end
	end

	// ------------------------------------------ stage 3 and divider stages
	// the quotient is below 2^STAMP_BITS, so the upper half of the magnitude
	// is already below the divisor and seeds the partial remainder
	logic [DW-1:0] rem_sd [W+1];
	logic [W-1:0]  low_sd [W+1];
	logic [DW-1:0] den_sd [W+1];
	logic          neg_sd [W+1];
	logic          v_sd   [W+1];

	logic           neg_c;
	logic [2*W-1:0] mag_c;

	always_comb begin
		neg_c = pos_s2 < sub_s2;
		mag_c = neg_c ? (sub_s2 - pos_s2) : (pos_s2 - sub_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd[0] <= 1'b0;
		end else if (adv) begin
			v_sd[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_sd[0] <= DW'(mag_c[2*W-1:W]);
			low_sd[0] <= mag_c[W-1:0];
			den_sd[0] <= den_s2;
			neg_sd[0] <= neg_c;
		end
	end

	// one restoring step per stage, quotient bits shift in behind the dividend
	for (genvar k = 0; k < W; k++) begin : g_div
		logic [DW:0] trial;
		logic        ge;
		logic [DW:0] diff;

		always_comb begin
			trial = {rem_sd[k], low_sd[k][W-1]};
			ge    = trial >= {1'b0, den_sd[k]};
			diff  = trial - {1'b0, den_sd[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k+1] <= 1'b0;
			end else if (adv) begin
				v_sd[k+1] <= v_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_sd[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				low_sd[k+1] <= {low_sd[k][W-2:0], ge};
				den_sd[k+1] <= den_sd[k];
				neg_sd[k+1] <= neg_sd[k];
			end
		end
	end

	// ------------------------------------ stage a: sign, flags, scale product
	logic [W-1:0]           quo;
	logic [W+TICK_BITS-1:0] quo_ext;
	logic [TICK_BITS-1:0]   quo_t;
	logic                   zero_c, negf_c;

	always_comb begin
		quo     = low_sd[W];
		quo_ext = (W + TICK_BITS)'(quo);
		quo_t   = quo_ext[TICK_BITS-1:0];
		zero_c  = den_sd[W] == '0;
		negf_c  = !zero_c && neg_sd[W] && quo != '0;
	end

	logic [TICK_BITS-1:0] ticks_sa;
	logic [PW-1:0]        prod_sa;
	logic                 negf_sa, zero_sa, v_sa;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sa <= 1'b0;
		end else if (adv) begin
			v_sa <= v_sd[W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			negf_sa  <= negf_c;
			zero_sa  <= zero_c;
			ticks_sa <= zero_c ? '0 : (negf_c ? (TICK_BITS'(0) - quo_t) : quo_t);
			// negative or undefined flight gives no distance
			prod_sa  <= (zero_c || negf_c) ? '0 : (PW'(quo) * PW'(scale_q));
		end
	end

	// --------------------------------- stage b: saturation and reciprocal mul
	logic [W+15:0]          hund_all;
	logic                   sat_c;
	logic [HLOW_BITS-1:0]   hlow_c;

	always_comb begin
		hund_all = prod_sa[PW-1:16];
		sat_c    = hund_all >= (W + 16)'(SAT_LIMIT);
		hlow_c   = sat_c ? '0 : hund_all[HLOW_BITS-1:0];
	end

	logic [HLOW_BITS+RECIP_BITS-1:0] rec_sb;
	logic [HLOW_BITS-1:0]            hlow_sb;
	logic [TICK_BITS-1:0]            ticks_sb;
	logic                            negf_sb, zero_sb, sat_sb, v_sb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sb <= 1'b0;
		end else if (adv) begin
			v_sb <= v_sa;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rec_sb   <= (HLOW_BITS + RECIP_BITS)'(hlow_c) *
			            (HLOW_BITS + RECIP_BITS)'(RECIP_K);
			hlow_sb  <= hlow_c;
			ticks_sb <= ticks_sa;
			negf_sb  <= negf_sa;
			zero_sb  <= zero_sa;
			sat_sb   <= sat_c;
		end
	end

	// -------------------------------------------------- stage c: whole cm
	logic [WHOLE_BITS-1:0] whole_sc;
	logic [HLOW_BITS-1:0]  hlow_sc;
	logic [TICK_BITS-1:0]  ticks_sc;
	logic                  negf_sc, zero_sc, sat_sc, v_sc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sc <= 1'b0;
		end else if (adv) begin
			v_sc <= v_sb;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			whole_sc <= rec_sb[RECIP_SHIFT +: WHOLE_BITS];
			hlow_sc  <= hlow_sb;
			ticks_sc <= ticks_sb;
			negf_sc  <= negf_sb;
			zero_sc  <= zero_sb;
			sat_sc   <= sat_sb;
		end
	end

	// ------------------------------------- output register: remainder in cm
	logic [HLOW_BITS-1:0] rem_c;

	always_comb begin
		rem_c = hlow_sc - (HLOW_BITS'(whole_sc) * HLOW_BITS'(CM_DIV));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_sc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flight_ticks  <= ticks_sc;
			whole_cm      <= sat_sc ? WHOLE_MAX : whole_sc;
			hundredths_cm <= sat_sc ? HUND_MAX : rem_c[HUND_BITS-1:0];
			was_negative  <= negf_sc;
			zero_divisor  <= zero_sc;
			saturated     <= sat_sc;
		end
	end

	// ------------------------------------------------------------ assertions
	// flags exclude each other
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones({was_negative, zero_divisor, saturated}) <= 1)
		else $error("more than one result flag set");

	// clamped or undefined flight carries no distance
	a_clamp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (was_negative || zero_divisor) |-> whole_cm == '0 && hundredths_cm == '0)
		else $error("clamped result has a distance");

	// hundredths always below one centimetre
	a_hund_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hundredths_cm <= HUND_MAX)
		else $error("hundredths out of range");

	// input is held off only while a finished word waits
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with free output");

endmodule

/* sim/tb_ds_twr_time_of_flight_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ds_twr_time_of_flight_top
// drives timestamp sets through the ranging block, predicts time of flight and
// distance in cm with exact wide arithmetic and compares every output word
// ----------------------------------------------------------------------------
module tb_ds_twr_time_of_flight_top;
	import dtof_pkg::*;

	localparam int LATENCY = 40;

	// one timestamp set as it goes into the block
	typedef struct {
		logic [31:0] p_poll, p_reply, p_final;
		logic [39:0] l_poll, l_reply, l_final;
	} stamps_t;

	// one distance word as it comes out
	typedef struct {
		logic [33:0] ticks;
		logic [15:0] whole;
		logic [6:0]  hund;
		logic        neg, zdiv, sat;
	} range_t;

	// directed row: stamps, plus an expected word where it is obvious
	typedef struct {
		stamps_t st;
		bit      typed;
		range_t  res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] peer_poll_sent = '0, peer_reply_seen = '0, peer_final_sent = '0;
	logic [39:0] local_poll_seen = '0, local_reply_sent = '0, local_final_seen = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [TICK_BITS-1:0] flight_ticks;
	logic [WHOLE_BITS-1:0] whole_cm;
	logic [HUND_BITS-1:0] hundredths_cm;
	logic was_negative, zero_divisor, saturated;

	logic [31:0] scale_q16;
	range_t pending_ranges[$];
	int fail_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	ds_twr_time_of_flight_top DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.peer_poll_sent(peer_poll_sent), .peer_reply_seen(peer_reply_seen),
		.peer_final_sent(peer_final_sent), .local_poll_seen(local_poll_seen),
		.local_reply_sent(local_reply_sent), .local_final_seen(local_final_seen),
		.out_valid(out_valid), .out_stall(out_stall),
		.flight_ticks(flight_ticks), .whole_cm(whole_cm), .hundredths_cm(hundredths_cm),
		.was_negative(was_negative), .zero_divisor(zero_divisor), .saturated(saturated)
	);

	always #2 clk = ~clk;

	// ranging math: wrap the intervals, exact 128-bit products, truncating quotient
	function automatic range_t range_of(stamps_t st);
		logic [31:0] ra, rb, da, db;
		logic [33:0] den;
		logic [127:0] pos, sub, mag, q, hcm;
		logic [127:0] whole_w;
		range_t r;
		ra = st.p_reply - st.p_poll;
		rb = st.l_final[31:0] - st.l_reply[31:0];
		da = st.p_final - st.p_reply;
		db = st.l_reply[31:0] - st.l_poll[31:0];
		den = 34'(ra) + 34'(rb) + 34'(da) + 34'(db);
		r = '{default: '0};
		if (den == 0) begin
			r.zdiv = 1'b1;
			return r;
		end
		pos = 128'(ra) * 128'(rb);
		sub = 128'(da) * 128'(db);
		mag = (pos < sub) ? sub - pos : pos - sub;
		q = mag / 128'(den);
		if (pos < sub && q != 0) begin
			r.neg = 1'b1;
			r.ticks = 34'(-q);
			return r;
		end
		r.ticks = q[33:0];
		hcm = (q * 128'(scale_q16)) >> 16;
		hcm = 128'(hcm[63:0]);
		whole_w = hcm / 100;
		if (whole_w > 65535) begin
			r.whole = WHOLE_MAX;
			r.hund = HUND_MAX;
			r.sat = 1'b1;
		end else begin
			r.whole = whole_w[15:0];
			r.hund = 7'(hcm % 100);
		end
		return r;
	endfunction

	// apb write: setup then access
	task automatic write_scale(logic [31:0] v);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; paddr = ADDR_BITS'({REG_SCALE, 2'b00}); pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		scale_q16 = v;
	endtask

	// present one word, hold it until the block takes it
	task automatic send_stamps(stamps_t st, bit typed, range_t res);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clk);
		in_valid = 1'b1;
		peer_poll_sent = st.p_poll; peer_reply_seen = st.p_reply;
		peer_final_sent = st.p_final; local_poll_seen = st.l_poll;
		local_reply_sent = st.l_reply; local_final_seen = st.l_final;
		do @(posedge clk); while (in_stall);
		pending_ranges.push_back(typed ? res : range_of(st));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain;
		while (pending_ranges.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// realistic exchange: flight and reply delays mostly short, one in four full range; random epoch and upper bits
	function automatic stamps_t ranging_exchange();
		stamps_t st;
		logic [31:0] t0, tof, ra_d, rb_d, loc0;
		tof = ($urandom_range(3) == 0) ? $urandom : $urandom_range(20000);
		ra_d = $urandom_range(3) == 0 ? $urandom : $urandom_range(4000000);
		rb_d = $urandom_range(3) == 0 ? $urandom : $urandom_range(4000000);
		t0 = $urandom;
		loc0 = $urandom;
		st.p_poll = t0;
		st.p_reply = t0 + 2 * tof + rb_d;
		st.p_final = st.p_reply + ra_d;
		st.l_poll = {8'($urandom), loc0};
		st.l_reply = {8'($urandom), loc0 + rb_d};
		st.l_final = {8'($urandom), loc0 + rb_d + 2 * tof + ra_d};
		return st;
	endfunction

	function automatic stamps_t noise_stamps();
		stamps_t st;
		st.p_poll = $urandom; st.p_reply = $urandom; st.p_final = $urandom;
		st.l_poll = {8'($urandom), 32'($urandom)};
		st.l_reply = {8'($urandom), 32'($urandom)};
		st.l_final = {8'($urandom), 32'($urandom)};
		return st;
	endfunction

	// receiver: random stall, compare each accepted word with the oldest expectation
	always @(negedge clk)
		out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);

	always @(posedge clk) begin
		range_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_ranges.size() == 0) begin
				$error("output word with nothing expected");
				fail_count++;
			end else begin
				e = pending_ranges.pop_front();
				if (flight_ticks !== e.ticks) begin
					$error("flight_ticks exp %h got %h", e.ticks, flight_ticks);
					fail_count++;
				end
				if (whole_cm !== e.whole) begin
					$error("whole_cm exp %0d got %0d", e.whole, whole_cm);
					fail_count++;
				end
				if (hundredths_cm !== e.hund) begin
					$error("hundredths_cm exp %0d got %0d", e.hund, hundredths_cm);
					fail_count++;
				end
				if (was_negative !== e.neg) begin
					$error("was_negative exp %b got %b", e.neg, was_negative);
					fail_count++;
				end
				if (zero_divisor !== e.zdiv) begin
					$error("zero_divisor exp %b got %b", e.zdiv, zero_divisor);
					fail_count++;
				end
				if (saturated !== e.sat) begin
					$error("saturated exp %b got %b", e.sat, saturated);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#4000000;
		$display("ds_twr_time_of_flight_top test failed");
		$finish;
	end

	initial begin
		row_t rows[$];
		row_t rw;
		range_t none;
		logic [31:0] scales[4];
		int phase;
		none = '{default: '0};
		scale_q16 = SCALE_RESET;

		// all stamps equal: zero interval sum
		rw.st = '{default: '0}; rw.typed = 1; rw.res = none; rw.res.zdiv = 1;
		rows.push_back(rw);
		rw.st = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			40'hFF_FFFFFFFF, 40'hFF_FFFFFFFF, 40'hFF_FFFFFFFF};
		rows.push_back(rw);
		// upper local bits only: still zero sum
		rw.st = '{0, 0, 0, 40'hAA_00000000, 40'h55_00000000, 40'hFF_00000000};
		rows.push_back(rw);
		// ra*rb = 0 with da*db > 0: negative flight
		rw.st = '{0, 0, 100, 0, 100, 100}; rw.typed = 1;
		rw.res = none; rw.res.neg = 1; rw.res.ticks = -34'sd50;
		rows.push_back(rw);
		// tiny negative that truncates to zero is not negative
		rw.st = '{0, 0, 1, 0, 1, 1}; rw.typed = 0; rows.push_back(rw);
		// only ra nonzero: tof 0
		rw.st = '{0, 5, 5, 0, 0, 0}; rw.typed = 1; rw.res = none; rows.push_back(rw);
		// max wrapped intervals: huge tof, saturates
		rw.st = '{1, 0, 0, 0, 0, 40'hFF_FFFFFFFF}; rw.typed = 1;
		rw.res = none; rw.res.ticks = 34'h7FFFFFFF; rw.res.whole = WHOLE_MAX;
		rw.res.hund = HUND_MAX; rw.res.sat = 1;
		rows.push_back(rw);
		rw.typed = 0;
		rw.st = '{32'hFFFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFD,
			40'h00_00000002, 40'h00_00000001, 40'hFF_00000000}; rows.push_back(rw);
		rw.st = '{0, 32'h80000000, 32'h80000000, 0, 0, 32'h80000000}; rows.push_back(rw);
		rw.st = '{0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 40'h01_FFFFFFFF}; rows.push_back(rw);
		// typical short flights, then an alternating bit pattern with a large negative flight
		rw.st = '{1000, 3001000, 5001000, 40'h12_00000000, 40'h12_002DC6C0,
			40'h12_004C4D00}; rows.push_back(rw);
		rw.st = '{32'hFFFFF000, 32'h00100000, 32'h00200000, 40'h80_FFFFF800,
			40'h80_000FF000, 40'h80_001FF200}; rows.push_back(rw);
		rw.st = '{32'h55555555, 32'hAAAAAAAA, 32'h55555555, 40'hAA_AAAAAAAA,
			40'h55_55555555, 40'hAA_AAAAAAAA}; rows.push_back(rw);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) send_stamps(rows[i].st, rows[i].typed, rows[i].res);
		drain();

		// random part: each phase under a different scale, extremes included
		scales = '{32'h0, 32'hFFFFFFFF, 32'h00010000, SCALE_RESET};
		for (phase = 0; phase < 4; phase++) begin
			write_scale(phase == 3 ? 32'($urandom) : scales[phase]);
			if (phase == 0) begin
				send_idle_pct = 33; recv_idle_pct = 82;
			end else if (phase == 1) begin
				send_idle_pct = 82; recv_idle_pct = 33;
			end else begin
				send_idle_pct = 0; recv_idle_pct = 0;
			end
			repeat (275) begin
				if ($urandom_range(9) < 8)
					send_stamps(ranging_exchange(), 0, none);
				else
					send_stamps(noise_stamps(), 0, none);
			end
			drain();
		end
		write_scale(SCALE_RESET);

		if (fail_count == 0)
			$display("ds_twr_time_of_flight_top test passed");
		else
			$display("ds_twr_time_of_flight_top test failed");
		$finish;
	end

endmodule
